>>> rtl/lbnc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbnc_pkg
// Shared constants, codes and types of the node coordinate cache.
// ---------------------------------------------------------------------------
package lbnc_pkg;

    localparam int OFFSET_BITS  = 6;
    localparam int INDEX_BITS   = 12;
    localparam int SLOTS        = 8;
    localparam int SPARSE_DEPTH = 512;

    localparam int ID_W     = INDEX_BITS + OFFSET_BITS;
    localparam int BLK_NODES = 1 << OFFSET_BITS;
    localparam int DIR_SIZE = 1 << INDEX_BITS;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int ENT_W    = $clog2(SLOTS + 1);
    localparam int NODE_AW  = SLOT_W + OFFSET_BITS;
    localparam int SP_AW    = $clog2(SPARSE_DEPTH);
    localparam int SP_CW    = SP_AW + 1;
    localparam int FILL_W   = OFFSET_BITS + 1;
    localparam int BYTES_W  = 16;
    localparam int TOTAL_W  = 11;
    localparam int COORD_W  = 64;
    localparam logic [BYTES_W-1:0] SLOT_BYTES  = BYTES_W'(BLK_NODES * 8);
    localparam logic [BYTES_W-1:0] TUPLE_BYTES = BYTES_W'(16);

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_DROP = 3'd2;
    localparam logic [2:0] ST_OVF  = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    localparam logic [2:0] REG_DENSE  = 3'd0;
    localparam logic [2:0] REG_SPARSE = 3'd1;
    localparam logic [2:0] REG_LOSSY  = 3'd2;
    localparam logic [2:0] REG_MAXB   = 3'd3;
    localparam logic [2:0] REG_SPCAP  = 3'd4;
    localparam logic [2:0] REG_BUDGET = 3'd5;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_LOOK, S_LOOK_WAIT, S_LOOK_DATA,
        S_BS_ISSUE, S_BS_WAIT, S_BS_CMP, S_BS_LAST, S_BS_LWAIT, S_BS_LCMP,
        S_PUT, S_UP, S_DOWN, S_SPILL_RD, S_SPILL_WAIT, S_SPILL_PUT,
        S_ALLOC, S_CLR_NODE, S_WRITE_CHK, S_WRITE, S_OUT
    } state_t;

endpackage
`default_nettype wire

>>> rtl/lbnc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lbnc_ram
// Single-port RAM with registered read.
// ---------------------------------------------------------------------------
module lbnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> rtl/lossy_block_node_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lossy_block_node_cache
// Two-tier node coordinate cache: block-indexed dense tier, sorted sparse tier.
// ---------------------------------------------------------------------------
// After reset the block sweeps its block directory, one entry a cycle, before
// it takes the first beat. Each item then runs through a small sequencer: a
// dense store or lookup passes through the directory and node memories; a
// sparse lookup adds a binary search of up to 10 steps; heap moves go one
// level at a time, and opening a new block clears its 64 valid bits, one a
// cycle, and a block spill reads its 64 entries one by one. One item is in
// work at a time.
module lossy_block_node_cache
    import lbnc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // node_id[17:0], lat[49:18], lon[81:50]
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // status[2:0], lat_out[34:3], lon_out[66:35],
                                        // stored_nodes[77:67]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [13:0] cfg_data
);
    // configuration
    logic dense_en_reg, sparse_en_reg, lossy_reg;
    logic [3:0] maxb_reg;
    logic [9:0] spcap_reg;
    logic [13:0] budget_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dense_en_reg <= 1'b1; sparse_en_reg <= 1'b1; lossy_reg <= 1'b1;
            maxb_reg <= 4'd8; spcap_reg <= 10'd512; budget_reg <= 14'd16383;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DENSE:  dense_en_reg <= cfg_data[0];
                REG_SPARSE: sparse_en_reg <= cfg_data[0];
                REG_LOSSY:  lossy_reg <= cfg_data[0];
                REG_MAXB:   maxb_reg <= cfg_data[3:0];
                REG_SPCAP:  spcap_reg <= cfg_data[9:0];
                REG_BUDGET: budget_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [ENT_W-1:0] maxb;
    logic [SP_CW-1:0] spcap;
    assign maxb  = (32'(maxb_reg) < SLOTS) ? ENT_W'(maxb_reg) : ENT_W'(SLOTS);
    assign spcap = (32'(spcap_reg) < SPARSE_DEPTH) ? SP_CW'(spcap_reg) : SP_CW'(SPARSE_DEPTH);

    // memories
    logic                   dir_we;
    logic [INDEX_BITS-1:0]  dir_addr;
    logic [ENT_W-1:0]       dir_wdata, dir_rdata;
    logic                   nd_we;
    logic [NODE_AW-1:0]     nd_addr;
    logic [COORD_W:0]       nd_wdata, nd_rdata;
    logic                   sp_we;
    logic [SP_AW-1:0]       sp_addr;
    logic [ID_W+COORD_W-1:0] sp_wdata, sp_rdata;

    lbnc_ram #(.WIDTH(ENT_W), .DEPTH(DIR_SIZE)) u_dir (
        .clk(clk), .we(dir_we), .addr(dir_addr), .wdata(dir_wdata), .rdata(dir_rdata));
    lbnc_ram #(.WIDTH(COORD_W + 1), .DEPTH(SLOTS * BLK_NODES)) u_node (
        .clk(clk), .we(nd_we), .addr(nd_addr), .wdata(nd_wdata), .rdata(nd_rdata));
    lbnc_ram #(.WIDTH(ID_W + COORD_W), .DEPTH(SPARSE_DEPTH)) u_sparse (
        .clk(clk), .we(sp_we), .addr(sp_addr), .wdata(sp_wdata), .rdata(sp_rdata));

    // state
    state_t state_reg, state_next;
    logic [INDEX_BITS-1:0] sowner_reg [SLOTS], sowner_next [SLOTS];
    logic [FILL_W-1:0]     fill_reg [SLOTS], fill_next [SLOTS];
    logic [SLOT_W-1:0]     heap_reg [SLOTS], heap_next [SLOTS];
    logic [ENT_W-1:0]      used_reg, used_next;
    logic [SP_CW-1:0]      spcnt_reg, spcnt_next;
    logic [ID_W-1:0]       lastid_reg, lastid_next;
    logic [BYTES_W-1:0]    bytes_reg, bytes_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;

    logic                  mode_reg, mode_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [COORD_W-1:0]    coord_reg, coord_next;
    logic [2:0]            st_reg, st_next;
    logic [COORD_W-1:0]    found_reg, found_next;
    logic [ENT_W-1:0]      e_reg, e_next;
    logic [SLOT_W-1:0]     s_reg, s_next, p_reg, p_next;
    logic [ENT_W-1:0]      pos_reg, pos_next;
    logic [OFFSET_BITS:0]  k_reg, k_next;
    logic [INDEX_BITS:0]   clr_reg, clr_next;
    logic [SP_CW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic                  upafter_reg, upafter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            used_reg <= '0; spcnt_reg <= '0; lastid_reg <= '0;
            bytes_reg <= '0; total_reg <= '0; clr_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            used_reg <= used_next; spcnt_reg <= spcnt_next; lastid_reg <= lastid_next;
            bytes_reg <= bytes_next; total_reg <= total_next; clr_reg <= clr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sowner_reg <= sowner_next; heap_reg <= heap_next;
        mode_reg <= mode_next; id_reg <= id_next; coord_reg <= coord_next;
        st_reg <= st_next; found_reg <= found_next; e_reg <= e_next;
        s_reg <= s_next; p_reg <= p_next; pos_reg <= pos_next; k_reg <= k_next;
        lo_reg <= lo_next; hi_reg <= hi_next;
        upafter_reg <= upafter_next;
    end

    // derived item fields
    logic [INDEX_BITS-1:0] blk;
    logic [OFFSET_BITS-1:0] off;
    logic in_range;
    assign blk = {~id_reg[ID_W-1], id_reg[ID_W-2:OFFSET_BITS]};
    assign off = id_reg[OFFSET_BITS-1:0];
    assign in_range = 1'b1;

    logic room;
    assign room = (used_reg < maxb) && (bytes_reg < BYTES_W'(budget_reg));

    // sparse put acceptance for a given id
    logic [ID_W-1:0] put_id;
    logic put_ok;
    assign put_ok = !((spcnt_reg != 0) && ($signed(put_id) < $signed(lastid_reg)))
                    && (spcnt_reg < spcap) && (bytes_reg <= BYTES_W'(budget_reg));

    logic [SP_CW-1:0] mid;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // heap helpers
    logic [SLOT_W-1:0] hp, hc, ha, hb;
    logic [ENT_W-1:0] par_pos, a_pos, b_pos, c_pos;
    assign par_pos = (pos_reg - ENT_W'(1)) >> 1;
    assign a_pos = ENT_W'(2) * pos_reg + ENT_W'(1);
    assign b_pos = a_pos + ENT_W'(1);
    assign hp = heap_reg[SLOT_W'(pos_reg)];
    assign ha = heap_reg[SLOT_W'(a_pos)];
    assign hb = heap_reg[SLOT_W'(b_pos)];
    assign c_pos = (fill_reg[ha] <= fill_reg[hb]) ? a_pos : b_pos;
    assign hc = heap_reg[SLOT_W'(c_pos)];

    logic [INDEX_BITS-1:0] sp_owner;
    assign sp_owner = sowner_reg[p_reg];

    always_comb
    begin
        state_next = state_reg;
        sowner_next = sowner_reg; fill_next = fill_reg; heap_next = heap_reg;
        used_next = used_reg; spcnt_next = spcnt_reg; lastid_next = lastid_reg;
        bytes_next = bytes_reg; total_next = total_reg; clr_next = clr_reg;
        mode_next = mode_reg; id_next = id_reg; coord_next = coord_reg;
        st_next = st_reg; found_next = found_reg; e_next = e_reg;
        s_next = s_reg; p_next = p_reg; pos_next = pos_reg; k_next = k_reg;
        lo_next = lo_reg; hi_next = hi_reg;
        upafter_next = upafter_reg;
        dir_we = 1'b0; dir_addr = blk; dir_wdata = '0;
        nd_we = 1'b0; nd_addr = {s_reg, off}; nd_wdata = '0;
        sp_we = 1'b0; sp_addr = SP_AW'(mid); sp_wdata = '0;
        put_id = id_reg;
        s_tready = 1'b0; m_tvalid = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                dir_we = 1'b1; dir_addr = clr_reg[INDEX_BITS-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg[INDEX_BITS-1:0] == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mode_next = s_tuser;
                    id_next = s_tdata[ID_W-1:0];
                    coord_next = {s_tdata[49:18], s_tdata[81:50]};
                    found_next = '0;
                    st_next = ST_OK;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // directory read issued at blk
                if (!in_range)
                begin
                    st_next = ST_RANGE; state_next = S_OUT;
                end
                else if (mode_reg)
                begin
                    state_next = S_LOOK;
                end
                else if (dense_en_reg)
                begin
                    if (maxb == 0)
                    begin
                        st_next = ST_DROP; state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else if (sparse_en_reg)
                begin
                    if (put_ok)
                    begin
                        sp_we = 1'b1; sp_addr = SP_AW'(spcnt_reg);
                        sp_wdata = {id_reg, coord_reg};
                        spcnt_next = spcnt_reg + 1'b1; lastid_next = id_reg;
                        bytes_next = bytes_reg + TUPLE_BYTES; total_next = total_reg + 1'b1;
                    end
                    else
                    begin
                        st_next = lossy_reg ? ST_DROP : ST_OVF;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    st_next = ST_DROP; state_next = S_OUT;
                end
            end
            S_LOOK:
            begin
                e_next = dir_rdata;
                s_next = SLOT_W'(dir_rdata - 1'b1);
                state_next = S_LOOK_WAIT;
            end
            S_LOOK_WAIT:
            begin
                state_next = S_LOOK_DATA;
            end
            S_LOOK_DATA:
            begin
                if (dense_en_reg && e_reg != 0 && nd_rdata[COORD_W])
                begin
                    found_next = nd_rdata[COORD_W-1:0]; st_next = ST_OK; state_next = S_OUT;
                end
                else if (sparse_en_reg)
                begin
                    lo_next = '0; hi_next = spcnt_reg; state_next = S_BS_ISSUE;
                end
                else
                begin
                    st_next = ST_MISS; state_next = S_OUT;
                end
            end
            S_BS_ISSUE:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = S_BS_WAIT;
                end
                else if (lo_reg == 0)
                begin
                    st_next = ST_MISS; state_next = S_OUT;
                end
                else
                begin
                    sp_addr = SP_AW'(lo_reg - 1'b1); state_next = S_BS_LWAIT;
                end
            end
            S_BS_WAIT:
            begin
                state_next = S_BS_CMP;
            end
            S_BS_CMP:
            begin
                if ($signed(sp_rdata[ID_W+COORD_W-1:COORD_W]) <= $signed(id_reg))
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_BS_ISSUE;
            end
            S_BS_LWAIT:
            begin
                sp_addr = SP_AW'(lo_reg - 1'b1); state_next = S_BS_LCMP;
            end
            S_BS_LCMP:
            begin
                if (sp_rdata[ID_W+COORD_W-1:COORD_W] == id_reg)
                begin
                    found_next = sp_rdata[COORD_W-1:0]; st_next = ST_OK;
                end
                else
                begin
                    st_next = ST_MISS;
                end
                state_next = S_OUT;
            end
            S_PUT:
            begin
                e_next = dir_rdata;
                if (dir_rdata != 0)
                begin
                    s_next = SLOT_W'(dir_rdata - 1'b1);
                    if (used_reg == 0 ||
                        heap_reg[SLOT_W'(room ? used_reg - 1'b1 : '0)] !=
                        SLOT_W'(dir_rdata - 1'b1))
                    begin
                        st_next = ST_DROP; state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_WRITE_CHK;
                    end
                end
                else if (room)
                begin
                    s_next = SLOT_W'(used_reg);
                    if (used_reg > 0)
                    begin
                        p_next = heap_reg[SLOT_W'(used_reg - 1'b1)];
                        if (!sparse_en_reg ||
                            fill_reg[heap_reg[SLOT_W'(used_reg - 1'b1)]] >
                            FILL_W'(BLK_NODES / 2))
                        begin
                            pos_next = used_reg - 1'b1; upafter_next = 1'b0;
                            state_next = S_UP;
                        end
                        else
                        begin
                            k_next = '0; state_next = S_SPILL_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
                else if (!lossy_reg)
                begin
                    st_next = ST_OVF; state_next = S_OUT;
                end
                else if (used_reg == 0)
                begin
                    st_next = ST_DROP; state_next = S_OUT;
                end
                else
                begin
                    pos_next = '0; state_next = S_DOWN;
                end
            end
            S_UP:
            begin
                if (pos_reg > 0 && fill_reg[hp] < fill_reg[heap_reg[SLOT_W'(par_pos)]])
                begin
                    heap_next[SLOT_W'(pos_reg)] = heap_reg[SLOT_W'(par_pos)];
                    heap_next[SLOT_W'(par_pos)] = hp;
                    pos_next = par_pos;
                end
                else
                begin
                    state_next = upafter_reg ? S_CLR_NODE : S_ALLOC;
                    k_next = '0;
                end
            end
            S_DOWN:
            begin
                if ((ENT_W + 1)'(a_pos) + 1 < (ENT_W + 1)'(used_reg) &&
                    fill_reg[hp] > fill_reg[hc])
                begin
                    heap_next[SLOT_W'(pos_reg)] = hc;
                    heap_next[SLOT_W'(c_pos)] = hp;
                    pos_next = c_pos;
                end
                else
                begin
                    s_next = heap_reg[0];
                    dir_we = 1'b1; dir_addr = sowner_reg[heap_reg[0]];
                    total_next = total_reg - TOTAL_W'(fill_reg[heap_reg[0]]);
                    fill_next[heap_reg[0]] = '0;
                    sowner_next[heap_reg[0]] = blk;
                    k_next = '0;
                    state_next = S_CLR_NODE;
                end
            end
            S_SPILL_RD:
            begin
                if (k_reg[OFFSET_BITS])
                begin
                    total_next = total_reg - TOTAL_W'(fill_reg[p_reg]);
                    dir_we = 1'b1; dir_addr = sp_owner;
                    used_next = used_reg - 1'b1;
                    bytes_next = bytes_reg - SLOT_BYTES;
                    s_next = p_reg;
                    state_next = S_ALLOC;
                end
                else
                begin
                    nd_addr = {p_reg, k_reg[OFFSET_BITS-1:0]};
                    state_next = S_SPILL_WAIT;
                end
            end
            S_SPILL_WAIT:
            begin
                nd_addr = {p_reg, k_reg[OFFSET_BITS-1:0]};
                state_next = S_SPILL_PUT;
            end
            S_SPILL_PUT:
            begin
                put_id = {~sp_owner[INDEX_BITS-1], sp_owner[INDEX_BITS-2:0],
                          k_reg[OFFSET_BITS-1:0]};
                if (nd_rdata[COORD_W])
                begin
                    if (put_ok)
                    begin
                        sp_we = 1'b1; sp_addr = SP_AW'(spcnt_reg);
                        sp_wdata = {put_id, nd_rdata[COORD_W-1:0]};
                        spcnt_next = spcnt_reg + 1'b1; lastid_next = put_id;
                        bytes_next = bytes_reg + TUPLE_BYTES; total_next = total_reg + 1'b1;
                    end
                    else if (!lossy_reg)
                    begin
                        st_next = ST_OVF;
                    end
                end
                k_next = k_reg + 1'b1;
                state_next = S_SPILL_RD;
            end
            S_ALLOC:
            begin
                fill_next[s_reg] = '0;
                sowner_next[s_reg] = blk;
                heap_next[SLOT_W'(used_reg)] = s_reg;
                used_next = used_reg + 1'b1;
                bytes_next = bytes_reg + SLOT_BYTES;
                k_next = '0;
                if (used_reg + 1'b1 == maxb ||
                    bytes_reg + SLOT_BYTES > BYTES_W'(budget_reg))
                begin
                    pos_next = used_reg; upafter_next = 1'b1; state_next = S_UP;
                end
                else
                begin
                    state_next = S_CLR_NODE;
                end
            end
            S_CLR_NODE:
            begin
                if (k_reg[OFFSET_BITS])
                begin
                    dir_we = 1'b1; dir_wdata = ENT_W'(s_reg) + 1'b1;
                    nd_addr = {s_reg, off};
                    state_next = S_WRITE_CHK;
                end
                else
                begin
                    nd_we = 1'b1; nd_addr = {s_reg, k_reg[OFFSET_BITS-1:0]};
                    k_next = k_reg + 1'b1;
                end
            end
            S_WRITE_CHK:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (!nd_rdata[COORD_W])
                begin
                    fill_next[s_reg] = fill_reg[s_reg] + 1'b1;
                    total_next = total_reg + 1'b1;
                end
                nd_we = 1'b1; nd_wdata = {1'b1, coord_reg};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tdata = {2'b00, total_reg, found_reg[31:0], found_reg[63:32], st_reg};

endmodule
`default_nettype wire
